>>> sv/f2h_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2h_pkg: shared types and constants
// Mode codes and field widths for the single to half precision converter.
// ----------------------------------------------------------------------------
package f2h_pkg;

   localparam int SINGLE_WIDTH = 32;
   localparam int MODE_WIDTH   = 3;
   localparam int HALF_WIDTH   = 16;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_NEAREST_EVEN = 3'd0,
      MODE_TOWARD_ZERO  = 3'd1,
      MODE_DOWN         = 3'd2,
      MODE_UP           = 3'd3
   } round_mode_type;

   typedef struct packed {
      logic [SINGLE_WIDTH-1:0] single_bits;
      logic [MODE_WIDTH-1:0]   round_mode;
   } req_word_type;

   typedef struct packed {
      logic [HALF_WIDTH-1:0] half_bits;
   } rsp_word_type;

endpackage

>>> sv/f2h_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2h_req_if: request channel
// Valid/ready channel that carries one single precision word and its mode.
// ----------------------------------------------------------------------------
interface f2h_req_if;
   import f2h_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

>>> sv/f2h_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2h_rsp_if: response channel
// Valid/ready channel that carries one half precision word.
// ----------------------------------------------------------------------------
interface f2h_rsp_if;
   import f2h_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

>>> sv/float32_to_float16_round_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_to_float16_round_unit: single to half precision conversion
// Rounds binary32 by the selected mode into binary16 (subnormals truncate).
// ----------------------------------------------------------------------------
// A request passes through the input register, then the result register.
// Throughput: one word per cycle; the input register and the result register
// each advance whenever the stage after them is free or being drained.
// Reset clears both valid flags; the data registers are not reset.
module float32_to_float16_round_unit (
   input logic clock,
   input logic reset,
   f2h_req_if.sink   req,
   f2h_rsp_if.source rsp
);
   import f2h_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff;
   logic         out_load;
   logic         in_ready;

   logic [31:0] x;
   logic [31:0] xr;
   logic        sign;
   logic [7:0]  expf;
   logic [9:0]  frac;
   logic        lost;
   logic        inc;
   logic [3:0]  sh;
   logic [10:0] sub_val;
   logic [15:0] half;

   assign out_load    = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign in_ready    = !in_valid_ff || out_load;
   assign req.ready   = in_ready;
   assign in_valid_in = (req.valid && in_ready) || (in_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp.ready);
   assign rsp.valid   = out_valid_ff;
   assign rsp.word    = out_word_ff;

   always_comb begin
      x       = in_word_ff.single_bits;
      sign    = x[31];
      lost    = x[12:0] != 13'd0;
      inc     = 1'b0;
      case (round_mode_type'(in_word_ff.round_mode))
         MODE_NEAREST_EVEN: inc = x[12] && (x[13] || x[11:0] != 12'd0);
         MODE_DOWN:         inc = lost && sign;
         MODE_UP:           inc = lost && !sign;
         default:           inc = 1'b0;
      endcase
      if (x[30:23] == 8'd0 || x[30:23] == 8'hFF) begin
         inc = 1'b0;
      end
      xr      = {1'b0, x[30:0]} + {18'd0, inc, 13'd0};
      expf    = xr[30:23];
      frac    = xr[22:13];
      sh      = 4'd0;
      sub_val = 11'd0;
      if (x[30:23] == 8'hFF) begin
         half = {sign, 5'h1F, (x[22:0] != 23'd0 && x[22:13] == 10'd0) ? 10'h3FF : x[22:13]};
      end else if (xr[31] || expf > 8'd142) begin
         half = {sign, 5'h1F, 10'd0};
      end else if (expf < 8'd103) begin
         half = {sign, 15'd0};
      end else if (expf < 8'd113) begin
         sh      = 4'(8'd113 - expf);
         sub_val = {1'b1, frac} >> sh;
         half    = {sign, 4'd0, sub_val};
      end else begin
         half = {sign, 5'(expf - 8'd112), frac};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req.valid && in_ready) begin
         in_word_ff <= req.word;
      end
      if (out_load) begin
         out_word_ff.half_bits <= half;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp.ready |=> out_valid_ff && $stable(out_word_ff))
      else $error("result word changed while stalled");
   a_nan: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_word_ff.single_bits[30:23] == 8'hFF
      && in_word_ff.single_bits[22:0] != 23'd0 |-> half[14:10] == 5'h1F && half[9:0] != 10'd0)
      else $error("NaN input did not give a NaN");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req.ready)
      else $error("empty input register refused a word");

endmodule
